// File: hw/rtl/qtd_pkg.sv
// ----------------------------------------------------------------------------
// qtd_pkg
// Shared types and constants for the Q-table TD update engine.
// ----------------------------------------------------------------------------
package qtd_pkg;

    localparam int VAL_W = 24;
    localparam int CNT_W = 16;

    localparam int MAX_STATES  = 256;
    localparam int MAX_ACTIONS = 8;

    typedef enum logic [1:0] {
        OP_QLEARN = 2'd0,
        OP_SARSA  = 2'd1,
        OP_QUERY  = 2'd2,
        OP_WRITE  = 2'd3
    } t_op;

    localparam logic [1:0] REG_ALPHA   = 2'd0;
    localparam logic [1:0] REG_GAMMA   = 2'd1;
    localparam logic [1:0] REG_STATES  = 2'd2;
    localparam logic [1:0] REG_ACTIONS = 2'd3;

    typedef struct packed {
        logic [1:0]         operation;
        logic [7:0]         state_index;
        logic [2:0]         action_index;
        logic [7:0]         next_state_index;
        logic [2:0]         next_action_index;
        logic signed [23:0] reward;
        logic signed [23:0] write_value;
    } t_req;

    typedef struct packed {
        logic signed [23:0] td_error;
        logic signed [23:0] entry_value;
        logic [2:0]         greedy_action;
        logic [15:0]        visit_count;
        logic               index_error;
    } t_rsp;

endpackage

// File: hw/rtl/q_table_td_update_engine_unit.sv
// ----------------------------------------------------------------------------
// q_table_td_update_engine_unit
// Tabular Q-learning / SARSA update engine with greedy query and direct write.
// ----------------------------------------------------------------------------
// After reset the block sweeps all MAX_STATES*MAX_ACTIONS = 2048 entries of both
// tables to zero, one entry per cycle, before taking requests.
// Requests are handled one at a time through a single-port value RAM and a
// single-port count RAM, one access per cycle each: a Q-learning update or a
// query scans the row one entry a cycle (actions_in_use reads unless the row
// is skipped as out of range), then the update reads the current entry, does
// gamma*Qnext and alpha*delta in two registered multiply steps and writes
// back. The response waits in an output register; the next request is taken
// once the response is taken, or at the same edge.
module q_table_td_update_engine_unit
    import qtd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [16:0] i_cfg_data,
    input  logic        i_valid,
    output logic        o_ready,
    input  t_req        i_req,
    output logic        o_valid,
    input  logic        i_ready,
    output t_rsp        o_rsp
);
    localparam int AW    = $clog2(MAX_ACTIONS);
    localparam int SW    = $clog2(MAX_STATES);
    localparam int DEPTH = MAX_STATES * MAX_ACTIONS;
    localparam int DW    = SW + AW;
    localparam int SCW   = SW + 1;
    localparam int ACW   = AW + 1;

    typedef enum logic [3:0] {
        ST_CLEAR, ST_IDLE, ST_SCAN, ST_SCAN_LAST, ST_NEXT_RD, ST_CUR_RD,
        ST_CUR_WAIT, ST_MUL_G, ST_DELTA, ST_MUL_A, ST_WRITE, ST_DONE
    } t_state;

    t_state r_st;
    logic [15:0] r_alpha;
    logic [16:0] r_gamma;
    logic [8:0]  r_states;
    logic [3:0]  r_actions;
    t_req        r_req;
    logic [DW-1:0]  r_clr;
    logic [ACW-1:0] r_scan;
    logic [ACW-1:0] r_got;
    logic signed [VAL_W-1:0] r_best;
    logic [2:0]  r_best_a;
    logic signed [VAL_W-1:0] r_next;
    logic signed [VAL_W-1:0] r_old;
    logic [CNT_W-1:0] r_cnt;
    logic signed [42:0] r_prod;
    logic signed [VAL_W-1:0] r_delta;
    logic r_cur_ok, r_err;
    logic r_ovalid;
    t_rsp r_rsp;

    logic [SCW-1:0] w_eff_s;
    logic [ACW-1:0] w_eff_a;
    logic [16:0]    w_gamma;
    logic           w_cur_ok, w_ns_ok, w_na_ok;

    always_comb begin
        w_eff_s = (r_states > 9'(MAX_STATES)) ? SCW'(MAX_STATES) : SCW'(r_states);
        w_eff_a = (r_actions > 4'(MAX_ACTIONS)) ? ACW'(MAX_ACTIONS) : ACW'(r_actions);
        w_gamma = (r_gamma > 17'd65536) ? 17'd65536 : r_gamma;
        w_cur_ok = (SCW'(r_req.state_index) < w_eff_s) && (ACW'(r_req.action_index) < w_eff_a);
        w_ns_ok = SCW'(r_req.next_state_index) < w_eff_s;
        w_na_ok = ACW'(r_req.next_action_index) < w_eff_a;
    end

    // memory interface
    logic              w_qwe, w_cwe;
    logic [DW-1:0]     w_addr;
    logic [VAL_W-1:0]  w_qwd, w_qrd;
    logic [CNT_W-1:0]  w_cwd, w_crd;
    logic [SW-1:0]     w_scan_s;
    logic signed [VAL_W-1:0] w_new;

    function automatic logic signed [VAL_W-1:0] sat(input logic signed [43:0] v);
        if (v > 44'sd8388607) begin
            sat = 24'sh7FFFFF;
        end else if (v < -44'sd8388608) begin
            sat = -24'sh800000;
        end else begin
            sat = v[VAL_W-1:0];
        end
    endfunction

    // round-half-up of a 2^16-scaled product
    function automatic logic signed [43:0] rnd(input logic signed [42:0] p);
        logic signed [43:0] t;
        t = 44'(p) + 44'sd32768;
        rnd = t >>> 16;
    endfunction

    always_comb begin
        w_scan_s = (r_req.operation == OP_QUERY) ? SW'(r_req.state_index)
                                                : SW'(r_req.next_state_index);
        w_new = sat(44'(r_old) + rnd(r_prod));
        w_qwe = 1'b0;
        w_cwe = 1'b0;
        w_qwd = '0;
        w_cwd = '0;
        w_addr = {SW'(r_req.state_index), AW'(r_req.action_index)};
        case (r_st)
            ST_CLEAR: begin
                w_qwe = 1'b1;
                w_cwe = 1'b1;
                w_addr = r_clr;
            end
            ST_SCAN: w_addr = {w_scan_s, AW'(r_scan)};
            ST_NEXT_RD: w_addr = {SW'(r_req.next_state_index), AW'(r_req.next_action_index)};
            ST_WRITE: begin
                w_qwe = r_cur_ok;
                w_cwe = r_cur_ok && (r_req.operation != OP_WRITE);
                w_qwd = (r_req.operation == OP_WRITE) ? r_req.write_value : w_new;
                w_cwd = (r_cnt == '1) ? r_cnt : r_cnt + 1'b1;
            end
            default: ;
        endcase
    end

    qtd_ram #(.WIDTH(VAL_W), .DEPTH(DEPTH)) u_qram (
        .i_clk(i_clk), .i_we(w_qwe), .i_addr(w_addr), .i_wdata(w_qwd), .o_rdata(w_qrd)
    );
    qtd_ram #(.WIDTH(CNT_W), .DEPTH(DEPTH)) u_cram (
        .i_clk(i_clk), .i_we(w_cwe), .i_addr(w_addr), .i_wdata(w_cwd), .o_rdata(w_crd)
    );

    assign o_ready = (r_st == ST_IDLE) && !(r_ovalid && !i_ready);
    assign o_valid = r_ovalid;
    assign o_rsp   = r_rsp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st      <= ST_CLEAR;
            r_clr     <= '0;
            r_alpha   <= 16'd6554;
            r_gamma   <= 17'd58982;
            r_states  <= 9'd256;
            r_actions <= 4'd5;
            r_ovalid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_ALPHA:   r_alpha   <= i_cfg_data[15:0];
                    REG_GAMMA:   r_gamma   <= i_cfg_data;
                    REG_STATES:  r_states  <= i_cfg_data[8:0];
                    REG_ACTIONS: r_actions <= i_cfg_data[3:0];
                    default: ;
                endcase
            end
            if (r_ovalid && i_ready) begin
                r_ovalid <= 1'b0;
            end
            // scan compare pipeline: read data arrives in the cycle after its address
            if ((r_st == ST_SCAN || r_st == ST_SCAN_LAST) && r_got != r_scan) begin
                if (r_got == '0 || $signed(w_qrd) > r_best) begin
                    r_best   <= w_qrd;
                    r_best_a <= 3'(r_got);
                end
                r_got <= r_got + 1'b1;
            end
            case (r_st)
                ST_CLEAR: begin
                    r_clr <= r_clr + 1'b1;
                    if (r_clr == DW'(DEPTH - 1)) begin
                        r_st <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (i_valid && o_ready) begin
                        r_req    <= i_req;
                        r_scan   <= '0;
                        r_got    <= '0;
                        r_best   <= '0;
                        r_best_a <= '0;
                        r_next   <= '0;
                        r_st     <= (i_req.operation == OP_SARSA) ? ST_NEXT_RD :
                                    (i_req.operation == OP_WRITE) ? ST_CUR_RD : ST_SCAN;
                    end
                end
                ST_SCAN: begin
                    if ((r_req.operation == OP_QUERY && SCW'(r_req.state_index) >= w_eff_s) ||
                        (r_req.operation == OP_QLEARN && !w_ns_ok) || w_eff_a == '0) begin
                        r_st <= (r_req.operation == OP_QUERY) ? ST_DONE : ST_CUR_RD;
                    end else if (r_scan == w_eff_a - 1'b1) begin
                        r_scan <= r_scan + 1'b1;
                        r_st   <= ST_SCAN_LAST;
                    end else begin
                        r_scan <= r_scan + 1'b1;
                    end
                end
                ST_SCAN_LAST: begin
                    r_next <= ($signed(w_qrd) > r_best || r_got == '0) ? w_qrd : r_best;
                    r_st   <= (r_req.operation == OP_QUERY) ? ST_DONE : ST_CUR_RD;
                end
                ST_NEXT_RD: r_st <= ST_CUR_RD;
                ST_CUR_RD: begin
                    if (r_req.operation == OP_SARSA) begin
                        r_next <= (w_ns_ok && w_na_ok) ? w_qrd : '0;
                    end
                    r_st <= ST_CUR_WAIT;
                end
                ST_CUR_WAIT: begin
                    r_cur_ok <= w_cur_ok;
                    r_old    <= w_cur_ok ? w_qrd : '0;
                    r_cnt    <= w_crd;
                    r_err    <= !w_cur_ok ||
                                (r_req.operation == OP_QLEARN && !w_ns_ok) ||
                                (r_req.operation == OP_SARSA && !(w_ns_ok && w_na_ok));
                    r_st     <= (r_req.operation == OP_WRITE) ? ST_WRITE : ST_MUL_G;
                end
                ST_MUL_G: begin
                    r_prod <= 43'($signed({1'b0, w_gamma})) * 43'(r_next);
                    r_st   <= ST_DELTA;
                end
                ST_DELTA: begin
                    r_delta <= sat(44'(r_req.reward) + rnd(r_prod) - 44'(r_old));
                    r_st    <= ST_MUL_A;
                end
                ST_MUL_A: begin
                    r_prod <= 43'($signed({1'b0, r_alpha})) * 43'(r_delta);
                    r_st   <= ST_WRITE;
                end
                ST_WRITE: begin
                    r_rsp.greedy_action <= '0;
                    r_rsp.index_error   <= r_err;
                    if (r_req.operation == OP_WRITE) begin
                        r_rsp.td_error    <= '0;
                        r_rsp.entry_value <= r_cur_ok ? r_req.write_value : '0;
                        r_rsp.visit_count <= r_cur_ok ? r_cnt : '0;
                    end else begin
                        r_rsp.td_error    <= r_delta;
                        r_rsp.entry_value <= r_cur_ok ? w_new : '0;
                        r_rsp.visit_count <= r_cur_ok ? w_cwd : '0;
                    end
                    r_ovalid <= 1'b1;
                    r_st     <= ST_IDLE;
                end
                ST_DONE: begin
                    r_rsp.td_error      <= '0;
                    r_rsp.greedy_action <= r_best_a;
                    r_rsp.entry_value   <= r_next;
                    r_rsp.index_error   <= SCW'(r_req.state_index) >= w_eff_s;
                    r_rsp.visit_count   <= w_cur_ok ? w_crd : '0;
                    r_ovalid <= 1'b1;
                    r_st     <= ST_IDLE;
                end
                default: r_st <= ST_IDLE;
            endcase
        end
    end

    // query: the count read at the current entry needs its address in the state before ST_DONE
    // (ST_SCAN_LAST addresses it via the default arm; after an early exit the count is unused)

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_qwe || w_cwe) |-> (r_st == ST_CLEAR || r_st == ST_WRITE))
        else $error("table write outside clear or write-back");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st == ST_WRITE && !r_cur_ok) |-> !w_qwe)
        else $error("write to out-of-range entry");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && !i_ready) |=> r_ovalid)
        else $error("response dropped");
endmodule

// File: hw/rtl/qtd_ram.sv
// ----------------------------------------------------------------------------
// qtd_ram
// Generic single-port synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module qtd_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 2048
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;
endmodule
